### sv/fcd_pkg.sv
// Package for the framebuffer circle drawer: commands, states, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcd_pkg;
    localparam int RasterWidth  = 128;
    localparam int RasterHeight = 128;
    localparam int ColorBits    = 24;
    localparam int FuncW        = 3;
    localparam int CoordW       = 7;
    localparam int OutColorW    = 24;

    localparam logic [FuncW-1:0] FUNC_CLEAR = 3'd0;
    localparam logic [FuncW-1:0] FUNC_WRITE = 3'd1;
    localparam logic [FuncW-1:0] FUNC_READ  = 3'd2;
    localparam logic [FuncW-1:0] FUNC_FILL  = 3'd3;
    localparam logic [FuncW-1:0] FUNC_RING  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL,
        ST_RING,
        ST_RD_WAIT,
        ST_RESP
    } t_state;

    // Ring sequencer: plot one of eight octant points per cycle, then step.
    typedef enum logic [1:0] {
        RG_PLOT,
        RG_STEP
    } t_ring_phase;
endpackage
`default_nettype wire

### sv/fcd_frame_mem.sv
// Frame store: single-port synchronous RAM, one write or one read per cycle.
// Depends on fcd_pkg for the default depth and data width.
`timescale 1ns / 1ps
`default_nettype none
module fcd_frame_mem import fcd_pkg::*; #(
    parameter int DEPTH = RasterWidth * RasterHeight,
    parameter int DATA_W = ColorBits
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [DATA_W-1:0]         i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write or read one word per cycle; read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

### sv/framebuffer_circle_drawer_top.sv
// Top level of the framebuffer circle drawer: command sequencer around one frame RAM.
// Depends on fcd_pkg and fcd_frame_mem.
`timescale 1ns / 1ps
`default_nettype none
// Takes one command item at a time and returns one result item per command.
// Write and unknown commands go straight to the result, reads wait for the
// registered RAM read, clear writes every word at one RAM write per cycle,
// a filled circle tests one candidate pixel per cycle over the bounding box,
// and an outline plots each set of eight symmetric points and then steps.
// All rates are set by the single write port of the frame RAM. Pixels outside
// the raster are skipped, never wrapped. The result waits in an output
// register until taken; the next command is accepted once it is taken.
module framebuffer_circle_drawer_top import fcd_pkg::*; #(
    parameter int RASTER_WIDTH  = RasterWidth,
    parameter int RASTER_HEIGHT = RasterHeight,
    parameter int COLOR_BITS    = ColorBits
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [FuncW-1:0]      i_func,
    input  wire [CoordW-1:0]     i_pos_x,
    input  wire [CoordW-1:0]     i_pos_y,
    input  wire [CoordW-1:0]     i_radius,
    input  wire [OutColorW-1:0]  i_paint_color,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [OutColorW-1:0] o_read_color,
    output logic                 o_done_res
);
    localparam int Depth = RASTER_WIDTH * RASTER_HEIGHT;
    localparam int AW    = $clog2(Depth);
    localparam int XW    = $clog2(RASTER_WIDTH);
    localparam int YW    = $clog2(RASTER_HEIGHT);
    localparam int SW    = 12;   // signed coords -127..254 and bounds up to 2047
    localparam int DW    = 12;   // midpoint decision range

    t_state              r_state, n_state;
    t_ring_phase         r_ph, n_ph;
    logic [COLOR_BITS-1:0] r_color, n_color;
    logic signed [SW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [SW-1:0] r_px, n_px, r_py, n_py;    // fill scan / ring a,b
    logic [CoordW-1:0]   r_rad, n_rad;
    logic [15:0]         r_r2, n_r2;
    logic signed [DW-1:0] r_d, n_d;
    logic [2:0]          r_oct, n_oct;
    logic [AW:0]         r_cnt, n_cnt;
    logic [OutColorW-1:0] r_out, n_out;
    logic                r_ovalid, n_ovalid;
    logic                r_rd_in, n_rd_in;

    // Memory port.
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_addr;
    logic [COLOR_BITS-1:0] mem_wdata;
    logic [COLOR_BITS-1:0] mem_rdata;

    logic signed [SW-1:0] plot_x, plot_y;
    logic                plot_in;
    logic signed [15:0]  dx, dy;
    logic [15:0]         dist2;
    logic                accept;

    fcd_frame_mem #(.DEPTH(Depth), .DATA_W(COLOR_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign accept       = i_valid && o_ready;
    assign o_ready      = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_read_color = r_out;
    assign o_done_res   = 1'b1;

    // Pick the candidate pixel for the current octant or scan position.
    always_comb begin
        dx = 16'(r_px - r_cx);
        dy = 16'(r_py - r_cy);
        plot_x = r_px;
        plot_y = r_py;
        if (r_state == ST_RING) begin
            case (r_oct)
                3'd0: begin plot_x = r_cx + r_px; plot_y = r_cy + r_py; end
                3'd1: begin plot_x = r_cx - r_px; plot_y = r_cy + r_py; end
                3'd2: begin plot_x = r_cx + r_px; plot_y = r_cy - r_py; end
                3'd3: begin plot_x = r_cx - r_px; plot_y = r_cy - r_py; end
                3'd4: begin plot_x = r_cx + r_py; plot_y = r_cy + r_px; end
                3'd5: begin plot_x = r_cx - r_py; plot_y = r_cy + r_px; end
                3'd6: begin plot_x = r_cx + r_py; plot_y = r_cy - r_px; end
                default: begin plot_x = r_cx - r_py; plot_y = r_cy - r_px; end
            endcase
        end
        dist2 = 16'(dx * dx) + 16'(dy * dy);
        plot_in = (plot_x >= 0) && (plot_x < SW'(RASTER_WIDTH))
               && (plot_y >= 0) && (plot_y < SW'(RASTER_HEIGHT));
    end

    // Sequencer: next state, RAM access and result.
    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_color  = r_color;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_px     = r_px;
        n_py     = r_py;
        n_rad    = r_rad;
        n_r2     = r_r2;
        n_d      = r_d;
        n_oct    = r_oct;
        n_cnt    = r_cnt;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_ready;
        n_rd_in  = r_rd_in;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wdata = r_color;
        mem_addr = AW'(32'(plot_y[YW-1:0]) * RASTER_WIDTH + 32'(plot_x[XW-1:0]));
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_color = i_paint_color[COLOR_BITS-1:0];
                    n_cx    = SW'(i_pos_x);
                    n_cy    = SW'(i_pos_y);
                    n_rad   = i_radius;
                    n_r2    = 16'(i_radius) * 16'(i_radius);
                    n_out   = '0;
                    n_cnt   = '0;
                    case (i_func)
                        FUNC_CLEAR: n_state = ST_CLEAR;
                        FUNC_WRITE: begin
                            n_px = SW'(i_pos_x);
                            n_py = SW'(i_pos_y);
                            n_state = ST_RESP;
                            mem_addr = AW'(32'(i_pos_y) * RASTER_WIDTH + 32'(i_pos_x));
                            mem_wdata = i_paint_color[COLOR_BITS-1:0];
                            mem_we = (32'(i_pos_x) < RASTER_WIDTH)
                                  && (32'(i_pos_y) < RASTER_HEIGHT);
                        end
                        FUNC_READ: begin
                            mem_addr = AW'(32'(i_pos_y) * RASTER_WIDTH + 32'(i_pos_x));
                            n_rd_in = (32'(i_pos_x) < RASTER_WIDTH)
                                   && (32'(i_pos_y) < RASTER_HEIGHT);
                            mem_re = 1'b1;
                            n_state = ST_RD_WAIT;
                        end
                        FUNC_FILL: begin
                            n_px = SW'(i_pos_x) - SW'(i_radius);
                            n_py = SW'(i_pos_y) - SW'(i_radius);
                            n_state = ST_FILL;
                        end
                        FUNC_RING: begin
                            n_px  = '0;
                            n_py  = SW'(i_radius);
                            n_d   = DW'(3) - DW'(2 * i_radius);
                            n_oct = '0;
                            n_ph  = RG_PLOT;
                            n_state = ST_RING;
                        end
                        default: n_state = ST_RESP;
                    endcase
                end
            end
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_cnt[AW-1:0];
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(Depth - 1)) begin
                    n_state = ST_RESP;
                end
            end
            ST_FILL: begin
                mem_we = plot_in && (dist2 < r_r2);
                if (r_py == r_cy + SW'(r_rad)) begin
                    n_py = r_cy - SW'(r_rad);
                    n_px = r_px + 1'b1;
                    if (r_px == r_cx + SW'(r_rad)) begin
                        n_state = ST_RESP;
                    end
                end else begin
                    n_py = r_py + 1'b1;
                end
            end
            ST_RING: begin
                if (r_ph == RG_PLOT) begin
                    mem_we = plot_in;
                    n_oct  = r_oct + 1'b1;
                    if (r_oct == 3'd7) begin
                        n_ph = RG_STEP;
                    end
                end else begin
                    // Loop test uses (a,b) of the plot just made.
                    if (r_py >= r_px) begin
                        n_px = r_px + 1'b1;
                        if (r_d > 0) begin
                            n_py = r_py - 1'b1;
                            n_d  = r_d + DW'(4 * (n_px - n_py)) + DW'(10);
                        end else begin
                            n_d  = r_d + DW'(4 * n_px) + DW'(6);
                        end
                        n_ph = RG_PLOT;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RD_WAIT: begin
                n_out   = r_rd_in ? OutColorW'(mem_rdata) : '0;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state; payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_ph     <= RG_PLOT;
            r_oct    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_ph     <= n_ph;
            r_oct    <= n_oct;
        end
        r_color <= n_color;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_px    <= n_px;
        r_py    <= n_py;
        r_rad   <= n_rad;
        r_r2    <= n_r2;
        r_d     <= n_d;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
        r_rd_in <= n_rd_in;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("accepted while busy");
    a_resp_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |=> o_valid) else $error("result lost");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP || r_state == ST_RD_WAIT) |-> !mem_we)
        else $error("stray write");
    a_read_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_re) |=> (r_state == ST_RD_WAIT)) else $error("read not awaited");
`endif
endmodule
`default_nettype wire

### sim/tb_framebuffer_circle_drawer_top.sv
// Self-checking testbench for the framebuffer circle drawer: random and directed commands,
// a frame store predictor and in-order result checks. Depends on fcd_pkg and the top level.
`timescale 1ns / 1ps
module tb_framebuffer_circle_drawer_top;
    import fcd_pkg::*;

    typedef struct {
        logic [FuncW-1:0]     func;
        logic [CoordW-1:0]    x;
        logic [CoordW-1:0]    y;
        logic [CoordW-1:0]    r;
        logic [OutColorW-1:0] color;
        bit                   drain;
    } t_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [FuncW-1:0]     i_func = '0;
    logic [CoordW-1:0]    i_pos_x = '0;
    logic [CoordW-1:0]    i_pos_y = '0;
    logic [CoordW-1:0]    i_radius = '0;
    logic [OutColorW-1:0] i_paint_color = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [OutColorW-1:0] o_read_color;
    logic                 o_done_res;

    t_cmd                 pending_cmds[$];
    logic [OutColorW-1:0] expected_colors[$];
    logic [ColorBits-1:0] frame_model[RasterWidth*RasterHeight];
    int                   cmds_total;
    int                   cmds_sent;
    int                   send_gap;
    int                   send_max_gap;
    int                   take_stall;
    int                   take_max_stall;
    bit                   failed;

    framebuffer_circle_drawer_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Paint one pixel, skipping anything off the raster.
    function automatic void paint_pixel(int px, int py, logic [ColorBits-1:0] c);
        if (px >= 0 && px < RasterWidth && py >= 0 && py < RasterHeight)
            frame_model[py*RasterWidth+px] = c;
    endfunction

    function automatic void paint_octants(int cx, int cy, int a, int b,
                                          logic [ColorBits-1:0] c);
        paint_pixel(cx+a, cy+b, c); paint_pixel(cx-a, cy+b, c);
        paint_pixel(cx+a, cy-b, c); paint_pixel(cx-a, cy-b, c);
        paint_pixel(cx+b, cy+a, c); paint_pixel(cx-b, cy+a, c);
        paint_pixel(cx+b, cy-a, c); paint_pixel(cx-b, cy-a, c);
    endfunction

    // Update the frame store for one command and return the expected read color.
    function automatic logic [OutColorW-1:0] apply_command(t_cmd c);
        int cx, cy, rr, a, b, d;
        logic [OutColorW-1:0] rd;
        cx = c.x; cy = c.y; rr = c.r; rd = '0;
        case (c.func)
            FUNC_CLEAR: foreach (frame_model[i]) frame_model[i] = c.color;
            FUNC_WRITE: paint_pixel(cx, cy, c.color);
            FUNC_READ:  rd = frame_model[cy*RasterWidth+cx];
            FUNC_FILL: begin
                for (int px = cx-rr; px <= cx+rr; px++)
                    for (int py = cy-rr; py <= cy+rr; py++)
                        if ((px-cx)*(px-cx) + (py-cy)*(py-cy) < rr*rr)
                            paint_pixel(px, py, c.color);
            end
            FUNC_RING: begin
                a = 0; b = rr; d = 3 - 2*rr;
                paint_octants(cx, cy, a, b, c.color);
                while (b >= a) begin
                    a++;
                    if (d > 0) begin
                        b--;
                        d = d + 4*(a-b) + 10;
                    end else begin
                        d = d + 4*a + 6;
                    end
                    paint_octants(cx, cy, a, b, c.color);
                end
            end
            default: ;
        endcase
        return rd;
    endfunction

    function automatic void add_cmd(logic [FuncW-1:0] f, int x, int y, int r,
                                    logic [OutColorW-1:0] c, bit drain = 0);
        t_cmd k;
        k.func = f; k.x = CoordW'(x); k.y = CoordW'(y); k.r = CoordW'(r);
        k.color = c; k.drain = drain;
        pending_cmds.push_back(k);
    endfunction

    function automatic int rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 3);
        if (sel == 1) return $urandom_range(124, 127);
        return $urandom_range(0, 127);
    endfunction

    // Drive command items; a drain item waits until every result is back.
    always @(posedge i_clk) begin
        bit free;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            free = !i_valid || o_ready;
            if (i_valid && o_ready) begin
                t_cmd k;
                k.func = i_func; k.x = i_pos_x; k.y = i_pos_y;
                k.r = i_radius; k.color = i_paint_color;
                expected_colors.push_back(apply_command(k));
                cmds_sent++;
                if (cmds_sent % 100 == 0) send_max_gap = $urandom_range(0, 1) ? 5 : 0;
                send_gap = $urandom_range(0, send_max_gap);
            end
            if (free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 &&
                             !(pending_cmds[0].drain && expected_colors.size() > 0)) begin
                    t_cmd k;
                    k = pending_cmds.pop_front();
                    i_func <= k.func; i_pos_x <= k.x; i_pos_y <= k.y;
                    i_radius <= k.r; i_paint_color <= k.color;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Take result items with random stalls and check them in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (o_valid && i_ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result, read_color %h", $time, o_read_color);
                failed = 1;
            end else begin
                logic [OutColorW-1:0] want;
                want = expected_colors.pop_front();
                if (o_read_color !== want) begin
                    $display("%0t: read_color expected %h actual %h",
                             $time, want, o_read_color);
                    failed = 1;
                end
                if (o_done_res !== 1'b1) begin
                    $display("%0t: done_res expected 1 actual %b", $time, o_done_res);
                    failed = 1;
                end
            end
            if ($urandom_range(0, 99) == 0) take_max_stall = $urandom_range(0, 1) ? 5 : 0;
            take_stall = $urandom_range(0, take_max_stall);
            i_ready <= (take_stall == 0);
        end else if (!i_ready) begin
            if (take_stall <= 1) i_ready <= 1'b1;
            else take_stall--;
        end
    end

    initial begin
        logic [FuncW-1:0] f;
        int sel, r;
        send_max_gap = 5;
        take_max_stall = 5;

        // Directed: clear first so every later read hits a written entry.
        add_cmd(FUNC_CLEAR, 0, 0, 0, 24'h123456);
        add_cmd(FUNC_READ, 64, 64, 0, 24'h0);
        add_cmd(FUNC_WRITE, 0, 0, 127, 24'hFFFFFF);
        add_cmd(FUNC_WRITE, 127, 127, 0, 24'h000000);
        add_cmd(FUNC_READ, 0, 0, 0, 24'hFFFFFF);
        add_cmd(FUNC_READ, 127, 127, 127, 24'hFFFFFF);
        add_cmd(FUNC_FILL, 0, 0, 5, 24'hAA55AA);
        add_cmd(FUNC_READ, 4, 0, 0, 24'h0);
        add_cmd(FUNC_FILL, 64, 64, 0, 24'h00FF00);
        add_cmd(FUNC_RING, 64, 64, 0, 24'h0000FF);
        add_cmd(FUNC_READ, 64, 64, 0, 24'h0);
        add_cmd(FUNC_RING, 127, 0, 10, 24'hFF0000);
        add_cmd(FUNC_RING, 64, 64, 127, 24'h00FFFF);
        add_cmd(FUNC_FILL, 127, 127, 127, 24'h5A5A5A, 1);
        add_cmd(FUNC_READ, 0, 0, 0, 24'h0);
        add_cmd(3'd5, 1, 2, 3, 24'hFFFFFF);
        add_cmd(3'd6, 127, 127, 127, 24'h0);
        add_cmd(3'd7, 0, 0, 0, 24'hFFFFFF);
        add_cmd(FUNC_READ, 127, 127, 0, 24'h0);

        // Random: mostly pixel traffic, rings of any radius, small fills, rare clears and big fills.
        for (int n = 0; n < 850; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2)       f = FUNC_CLEAR;
            else if (sel < 32) f = FUNC_WRITE;
            else if (sel < 62) f = FUNC_READ;
            else if (sel < 77) f = FUNC_FILL;
            else if (sel < 95) f = FUNC_RING;
            else               f = FuncW'($urandom_range(5, 7));
            if (f == FUNC_FILL)
                r = ($urandom_range(0, 99) == 0) ? $urandom_range(100, 127)
                                                 : $urandom_range(0, 20);
            else
                r = $urandom_range(0, 127);
            add_cmd(f, rand_coord(), rand_coord(), r, OutColorW'($urandom()),
                    $urandom_range(0, 199) == 0);
        end
        cmds_total = pending_cmds.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (cmds_sent == cmds_total && expected_colors.size() == 0);
        repeat (20) @(posedge i_clk);
        if (!failed && expected_colors.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit well past the slowest correct run.
    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

### sim.f
sv/fcd_pkg.sv
sv/fcd_frame_mem.sv
sv/framebuffer_circle_drawer_top.sv
sim/tb_framebuffer_circle_drawer_top.sv
